@@ design/dvr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dvr_pkg;
  localparam int unsigned GRID = 64;
  localparam int unsigned MAX_NODES_DEF = 64;
  localparam logic [9:0] NO_LINK = 10'd999;
  localparam logic [6:0] HOP_NONE = 7'd64;
  localparam logic [6:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_RECOMPUTE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LINK = 2'd0,
    KIND_DONE = 2'd1,
    KIND_HOP = 2'd2,
    KIND_UNREACH = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic       clr_step;   // sweep one entry of the table reset / clear pass
    logic       link_wr_ab;
    logic       link_wr_ba;
    logic       init_wr;    // write reset value into path/next at (i,j)
    logic       lk_rd;      // issue reads of link(i,k), path(k,j), path(i,j), hop(i,j)
    logic       relax;      // evaluate relaxation with registered reads
    logic       q_rd;       // read path/hop at (cur,dst)
    logic [5:0] i;
    logic [5:0] j;
    logic [5:0] k;
    logic [11:0] clr_addr;
  } dvr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       improved;  // strict improvement in this evaluation
    logic [9:0] rd_cost;   // path(i,j) as read
    logic [6:0] rd_hop;    // hop(i,j) as read
  } dvr_stat_t;
endpackage
`default_nettype wire

@@ design/dvr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dvr_datapath (
  input  wire logic              clk,
  input  wire dvr_pkg::dvr_cmd_t cmd,
  input  wire logic [5:0]        node_a,
  input  wire logic [5:0]        node_b,
  input  wire logic [9:0]        link_cost,
  output dvr_pkg::dvr_stat_t     stat
);
  import dvr_pkg::*;

  logic [9:0] link_mem [0:4095];
  logic [9:0] path_mem [0:4095];
  logic [6:0] hop_mem  [0:4095];

  logic [9:0] lk_q;
  logic [9:0] pk_q;
  logic [9:0] pij_q;
  logic [6:0] hij_q;
  logic [5:0] i_q;
  logic [5:0] j_q;
  logic [5:0] k_q;
  logic [11:0] ba_addr;
  logic [9:0]  ba_cost;

  logic [10:0] cand;
  logic        strict;
  logic        tie_take;
  logic [11:0] ij_addr;

  // link memory: one write port (clear, both directions take turns), one read
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      link_mem[cmd.clr_addr] <= (cmd.clr_addr[11:6] == cmd.clr_addr[5:0]) ? 10'd0 : NO_LINK;
    end else if (cmd.link_wr_ab) begin
      link_mem[{node_a, node_b}] <= link_cost;
    end else if (cmd.link_wr_ba) begin
      link_mem[ba_addr] <= ba_cost;
    end
    // hold the reverse direction, the input word may change after acceptance
    if (cmd.link_wr_ab) begin
      ba_addr <= {node_b, node_a};
      ba_cost <= link_cost;
    end
    lk_q <= link_mem[{cmd.i, cmd.k}];
  end

  assign cand = {1'b0, lk_q} + {1'b0, pk_q};
  assign strict = cand < {1'b0, pij_q};
  assign tie_take = (cand == {1'b0, pij_q}) && (k_q != i_q) && (hij_q != HOP_NONE) &&
                    ((hij_q == {1'b0, i_q}) || ({1'b0, k_q} < hij_q));
  assign ij_addr = {i_q, j_q};

  // path memory: second read port for path(k,j); writes at (i,j)
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      path_mem[cmd.clr_addr] <= (cmd.clr_addr[11:6] == cmd.clr_addr[5:0]) ? 10'd0 : NO_LINK;
      hop_mem[cmd.clr_addr] <= (cmd.clr_addr[11:6] == cmd.clr_addr[5:0]) ?
                               {1'b0, cmd.clr_addr[5:0]} : HOP_NONE;
    end else if (cmd.init_wr) begin
      path_mem[{cmd.i, cmd.j}] <= (cmd.i == cmd.j) ? 10'd0 : NO_LINK;
      hop_mem[{cmd.i, cmd.j}] <= (cmd.i == cmd.j) ? {1'b0, cmd.j} : HOP_NONE;
    end else if (cmd.relax && strict) begin
      path_mem[ij_addr] <= cand[9:0];
      hop_mem[ij_addr] <= {1'b0, k_q};
    end else if (cmd.relax && tie_take) begin
      hop_mem[ij_addr] <= {1'b0, k_q};
    end
    pk_q <= path_mem[{cmd.k, cmd.j}];
    pij_q <= path_mem[{cmd.i, cmd.j}];
    hij_q <= hop_mem[{cmd.i, cmd.j}];
    i_q <= cmd.i;
    j_q <= cmd.j;
    k_q <= cmd.k;
  end

  assign stat.improved = cmd.relax && strict;
  assign stat.rd_cost = pij_q;
  assign stat.rd_hop = hij_q;
endmodule
`default_nettype wire

@@ design/dvr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dvr_ctrl #(
  parameter int unsigned MAX_NODES = dvr_pkg::MAX_NODES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic [5:0]         node_a,
  input  wire logic [5:0]         node_b,
  input  wire logic [9:0]         link_cost,
  input  wire logic [6:0]         node_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic [5:0]              out_hop,
  output logic [9:0]              out_cost,
  output logic                    out_last,
  output dvr_pkg::dvr_cmd_t       cmd,
  input  wire dvr_pkg::dvr_stat_t stat
);
  import dvr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_LINKBA = 10'b0000000100,
    S_INIT   = 10'b0000001000,
    S_RD     = 10'b0000010000,
    S_EV     = 10'b0000100000,
    S_QRD    = 10'b0001000000,
    S_QEV    = 10'b0010000000,
    S_EMIT   = 10'b0100000000,
    S_DRAIN  = 10'b1000000000
  } state_t;

  state_t      state;
  logic [11:0] clr_addr;
  logic [5:0]  i;
  logic [5:0]  j;
  logic [5:0]  k;
  logic [6:0]  n;
  logic        improved;
  logic        first;
  logic [5:0]  dst;
  logic [5:0]  cur;
  logic [9:0]  qcost;
  logic [CW-1:0] cnt;
  logic [6:0]  nxt;
  logic        ob_full;

  logic [6:0] n_use;
  assign n_use = (node_count > 7'd64) ? 7'd64 : node_count;

  assign nxt = stat.rd_hop;

  logic out_fire;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state == S_IDLE) && !ob_full;
  assign out_valid = ob_full;

  always_comb begin
    cmd = '0;
    cmd.clr_addr = clr_addr;
    cmd.i = i;
    cmd.j = j;
    cmd.k = k;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: cmd.link_wr_ab = in_valid && in_ready && (in_command == CMD_SET);
      S_LINKBA: cmd.link_wr_ba = 1'b1;
      S_INIT: cmd.init_wr = 1'b1;
      S_RD: cmd.lk_rd = 1'b1;
      S_EV: cmd.relax = 1'b1;
      S_QRD: begin
        cmd.i = cur;
        cmd.j = dst;
        cmd.q_rd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      ob_full <= 1'b0;
      i <= '0;
      j <= '0;
      k <= '0;
      n <= '0;
      improved <= 1'b0;
      first <= 1'b0;
      cnt <= '0;
    end else begin
      if (out_fire) ob_full <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 12'd1;
          if (clr_addr == 12'hfff) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            case (in_command)
              CMD_SET: begin
                state <= S_LINKBA;
                out_kind <= KIND_LINK;
                out_hop <= node_a;
                out_cost <= link_cost;
                out_last <= 1'b1;
              end
              CMD_RECOMPUTE: begin
                n <= n_use;
                i <= '0;
                j <= '0;
                k <= '0;
                improved <= 1'b0;
                state <= (n_use == 7'd0) ? S_EMIT : S_INIT;
                out_kind <= KIND_DONE;
                out_hop <= '0;
                out_cost <= '0;
                out_last <= 1'b1;
              end
              CMD_QUERY: begin
                cur <= node_a;
                dst <= node_b;
                first <= 1'b1;
                cnt <= '0;
                state <= S_QRD;
              end
              default: ;
            endcase
          end
        end
        S_LINKBA: begin
          ob_full <= 1'b1;
          state <= S_IDLE;
        end
        S_INIT: begin
          if ({1'b0, j} == n - 7'd1) begin
            j <= '0;
            if ({1'b0, i} == n - 7'd1) begin
              i <= '0;
              state <= S_RD;
            end else begin
              i <= i + 6'd1;
            end
          end else begin
            j <= j + 6'd1;
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          // advance k fastest, then j, then i; repeat sweep while improving
          state <= S_RD;
          if (stat.improved) improved <= 1'b1;
          if ({1'b0, k} == n - 7'd1) begin
            k <= '0;
            if ({1'b0, j} == n - 7'd1) begin
              j <= '0;
              if ({1'b0, i} == n - 7'd1) begin
                i <= '0;
                if (improved || stat.improved) begin
                  improved <= 1'b0;
                end else begin
                  state <= S_EMIT;
                end
              end else begin
                i <= i + 6'd1;
              end
            end else begin
              j <= j + 6'd1;
            end
          end else begin
            k <= k + 6'd1;
          end
        end
        S_EMIT: begin
          ob_full <= 1'b1;
          state <= S_IDLE;
        end
        S_QRD: state <= S_QEV;
        S_QEV: begin
          if (first) begin
            qcost <= stat.rd_cost;
            out_hop <= cur;
            out_cost <= stat.rd_cost;
            if (stat.rd_cost == NO_LINK) begin
              out_kind <= KIND_UNREACH;
              out_last <= 1'b1;
            end else begin
              out_kind <= KIND_HOP;
              out_last <= !((cnt + CW'(1) < CW'(MAX_NODES)) && nxt[5:0] != dst
                            && nxt != HOP_NONE);
            end
          end else begin
            out_kind <= KIND_HOP;
            out_hop <= cur;
            out_cost <= qcost;
            out_last <= !((cnt + CW'(1) < CW'(MAX_NODES)) && nxt[5:0] != dst
                          && nxt != HOP_NONE);
          end
          first <= 1'b0;
          cur <= nxt[5:0];
          cnt <= cnt + CW'(1);
          ob_full <= 1'b1;
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (out_fire) begin
            state <= out_last ? S_IDLE : S_QRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/distance_vector_route_engine.sv @@
// Operation: a link set writes both directions; recompute resets the n x n route
// tables, then repeats sweeps until no entry improves; a query reads, evaluates and emits per hop.
// Throughput: one word at a time; the relaxation step (read, then compare/write on
// the single path table write port) sets the recompute rate.
// Reset: synchronous; a clearing pass over all 4096 entries restores all tables, during
// which no word is accepted. node_count resets to 64.
`timescale 1ns / 1ps
`default_nettype none
module distance_vector_route_engine #(
  parameter int unsigned MAX_NODES = dvr_pkg::MAX_NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[1:0], node_a[7:2], node_b[13:8], link_cost[23:14]
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // hop_node[5:0], route_cost[15:6]
  output logic [15:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import dvr_pkg::*;

  logic [6:0] node_count;
  dvr_cmd_t   cmd;
  dvr_stat_t  stat;
  logic [5:0] out_hop;
  logic [9:0] out_cost;

  always_ff @(posedge clk) begin
    if (rst) node_count <= NODE_COUNT_RST;
    else if (cfg_we) node_count <= cfg_wdata;
  end

  dvr_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_command(s_axis_tdata[1:0]), .node_a(s_axis_tdata[7:2]),
    .node_b(s_axis_tdata[13:8]), .link_cost(s_axis_tdata[23:14]),
    .node_count(node_count),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_kind(m_axis_tuser), .out_hop(out_hop), .out_cost(out_cost),
    .out_last(m_axis_tlast), .cmd(cmd), .stat(stat)
  );

  dvr_datapath u_dp (
    .clk(clk), .cmd(cmd),
    .node_a(s_axis_tdata[7:2]), .node_b(s_axis_tdata[13:8]),
    .link_cost(s_axis_tdata[23:14]), .stat(stat)
  );

  assign m_axis_tdata = {out_cost, out_hop};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result pending");
  a_unreach_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_UNREACH |-> m_axis_tlast)
    else $error("unreachable result not last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import dvr_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    kind_t      kind;
    logic [5:0] hop;
    logic [9:0] cost;
    logic       last;
  } route_word_t;

  class route_scoreboard;
    logic [9:0] link_tbl[4096];
    logic [9:0] cost_tbl[4096];
    logic [6:0] hop_tbl[4096];
    logic [6:0] node_count;
    route_word_t expected_words[$];
    int errors;

    function new();
      for (int i = 0; i < 64; i++) begin
        for (int j = 0; j < 64; j++) begin
          link_tbl[i*64+j] = (i == j) ? 10'd0 : NO_LINK;
          cost_tbl[i*64+j] = (i == j) ? 10'd0 : NO_LINK;
          hop_tbl[i*64+j] = (i == j) ? 7'(j) : HOP_NONE;
        end
      end
      node_count = NODE_COUNT_RST;
      errors = 0;
    endfunction

    function void push_word(kind_t kind, logic [5:0] hop, logic [9:0] cost, logic last);
      route_word_t w;
      w.kind = kind;
      w.hop = hop;
      w.cost = cost;
      w.last = last;
      expected_words.push_back(w);
    endfunction

    function void rebuild_routes();
      int n;
      int cur_idx;
      logic [10:0] cand;
      logic [6:0] h;
      bit improved;
      n = (node_count > 64) ? 64 : int'(node_count);
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          cost_tbl[i*64+j] = (i == j) ? 10'd0 : NO_LINK;
          hop_tbl[i*64+j] = (i == j) ? 7'(j) : HOP_NONE;
        end
      end
      do begin
        improved = 0;
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            for (int k = 0; k < n; k++) begin
              cur_idx = i*64+j;
              cand = {1'b0, link_tbl[i*64+k]} + {1'b0, cost_tbl[k*64+j]};
              if (cand < {1'b0, cost_tbl[cur_idx]}) begin
                cost_tbl[cur_idx] = cand[9:0];
                hop_tbl[cur_idx] = 7'(k);
                improved = 1;
              end else if (cand == {1'b0, cost_tbl[cur_idx]} && k != i) begin
                h = hop_tbl[cur_idx];
                // keep "none" as is; never route through the node itself
                if (h != HOP_NONE && (h == 7'(i) || 7'(k) < h))
                  hop_tbl[cur_idx] = 7'(k);
              end
            end
          end
        end
      end while (improved);
    endfunction

    function void note_command(cmd_t cmd, logic [5:0] a, logic [5:0] b, logic [9:0] cost);
      logic [9:0] route;
      logic [6:0] nxt;
      int cnt;
      case (cmd)
        CMD_SET: begin
          link_tbl[{a, b}] = cost;
          link_tbl[{b, a}] = cost;
          push_word(KIND_LINK, a, cost, 1'b1);
        end
        CMD_RECOMPUTE: begin
          rebuild_routes();
          push_word(KIND_DONE, 6'd0, 10'd0, 1'b1);
        end
        CMD_QUERY: begin
          route = cost_tbl[{a, b}];
          if (route == NO_LINK) begin
            push_word(KIND_UNREACH, a, NO_LINK, 1'b1);
          end else begin
            push_word(KIND_HOP, a, route, 1'b0);
            cnt = 1;
            nxt = hop_tbl[{a, b}];
            while (cnt < 64 && nxt != {1'b0, b} && nxt < 7'd64) begin
              push_word(KIND_HOP, nxt[5:0], route, 1'b0);
              cnt++;
              nxt = hop_tbl[{nxt[5:0], b}];
            end
            expected_words[expected_words.size()-1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(kind_t kind, logic [5:0] hop, logic [9:0] cost, logic last);
      route_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d hop %0d cost %0d", kind, hop, cost));
      end else begin
        w = expected_words.pop_front();
        if (kind !== w.kind || hop !== w.hop || cost !== w.cost || last !== w.last)
          report($sformatf("got kind %0d hop %0d cost %0d last %0b, want %0d %0d %0d %0b",
                           kind, hop, cost, last, w.kind, w.hop, w.cost, w.last));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  route_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int recv_hold;
  int quiet_cycles;

  distance_vector_route_engine dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus an optional long hold-off
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_command(cmd_t'(s_axis_tdata[1:0]), s_axis_tdata[7:2], s_axis_tdata[13:8],
                        s_axis_tdata[23:14]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(kind_t'(m_axis_tuser), m_axis_tdata[5:0], m_axis_tdata[15:6],
                      m_axis_tlast);
    end
  end

  // watchdog: count cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_word(cmd_t cmd, logic [5:0] a, logic [5:0] b, logic [9:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {cost, b, a, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task wait_drained();
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_node_count(logic [6:0] value);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = value;
    sb.node_count = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task send_random(int count, int span, bit sweeps = 1'b1);
    int r;
    logic [5:0] a;
    logic [5:0] b;
    logic [9:0] cost;
    for (int n = 0; n < count; n++) begin
      a = ($urandom_range(99) < 85) ? 6'($urandom_range(span - 1)) : 6'($urandom_range(63));
      b = ($urandom_range(99) < 85) ? 6'($urandom_range(span - 1)) : 6'($urandom_range(63));
      r = $urandom_range(99);
      if (r < 8) cost = 10'($urandom_range(1023));
      else if (r < 20) cost = NO_LINK;
      else cost = 10'($urandom_range(20));
      r = $urandom_range(99);
      if (r < 40) send_word(CMD_SET, a, b, cost);
      else if (r < 50 && sweeps) send_word(CMD_RECOMPUTE, a, b, cost);
      else if (r < 95) send_word(CMD_QUERY, a, b, cost);
      else send_word(CMD_NONE, a, b, cost);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 7'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 24'd0;
    m_axis_tready = 1'b0;
    recv_hold = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: ties, oversize cost, self route, unreachable, unknown command
    write_node_count(7'd4);
    send_word(CMD_SET, 6'd0, 6'd1, 10'd2);
    send_word(CMD_SET, 6'd1, 6'd3, 10'd2);
    send_word(CMD_SET, 6'd0, 6'd2, 10'd2);
    send_word(CMD_SET, 6'd2, 6'd3, 10'd2);
    send_word(CMD_SET, 6'd63, 6'd63, 10'd1023);
    send_word(CMD_SET, 6'd1, 6'd2, 10'd0);
    send_word(CMD_RECOMPUTE, 6'd0, 6'd0, 10'd0);
    send_word(CMD_QUERY, 6'd0, 6'd3, 10'd0);
    send_word(CMD_QUERY, 6'd3, 6'd0, 10'd0);
    send_word(CMD_QUERY, 6'd2, 6'd2, 10'd0);
    send_word(CMD_QUERY, 6'd0, 6'd63, 10'd0);
    send_word(CMD_QUERY, 6'd63, 6'd63, 10'd0);
    send_word(CMD_NONE, 6'd63, 6'd63, 10'd1023);
    send_word(CMD_SET, 6'd1, 6'd2, NO_LINK);
    send_word(CMD_SET, 6'd0, 6'd2, 10'd999);
    send_word(CMD_RECOMPUTE, 6'd63, 6'd63, 10'd1023);
    send_word(CMD_QUERY, 6'd2, 6'd0, 10'd0);
    send_word(CMD_QUERY, 6'd0, 6'd2, 10'd0);

    write_node_count(7'd0);
    send_word(CMD_RECOMPUTE, 6'd0, 6'd0, 10'd0);
    send_word(CMD_QUERY, 6'd0, 6'd3, 10'd0);
    write_node_count(7'd1);
    send_word(CMD_RECOMPUTE, 6'd0, 6'd0, 10'd0);
    send_word(CMD_QUERY, 6'd0, 6'd0, 10'd0);
    send_word(CMD_QUERY, 6'd0, 6'd1, 10'd0);

    // random phases with different idling
    write_node_count(7'd5);
    send_random(15, 5);
    write_node_count(7'd8);
    send_idle_pct = 84;
    send_random(15, 8);
    write_node_count(7'd6);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    send_random(15, 6);
    write_node_count(7'd3);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    send_random(15, 3);

    // hold off the receiver so the engine backs up, then drain fully
    recv_hold = 400;
    send_idle_pct = 0;
    for (int n = 0; n < 12; n++) send_word(CMD_QUERY, 6'($urandom_range(2)),
                                           6'($urandom_range(2)), 10'd0);
    wait_drained();
    send_random(10, 3);

    // large node counts: links and queries only, no full sweep
    write_node_count(7'd127);
    send_random(8, 64, 1'b0);
    write_node_count(7'd64);
    for (int n = 0; n < 8; n++) begin
      if (n % 2 == 0)
        send_word(CMD_SET, 6'($urandom_range(63)), 6'($urandom_range(63)),
                  10'($urandom_range(1023)));
      else
        send_word(CMD_QUERY, 6'($urandom_range(63)), 6'($urandom_range(63)), 10'd0);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
